// ----- hdl/lrn_pkg.sv -----
// Package for the leaky recurrent network step core.
// Holds shared sizes, command and status types, and the squash table.
package lrn_pkg;

  localparam int LAYERS_DEF = 4;
  localparam int NUM_ACTIONS_DEF = 4;
  localparam int NUM_STATES_DEF = 4;
  localparam int MEM_WORDS_DEF = 8;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic clr_start;
    logic ld_act;
    logic acc_clr;
    logic mac_en;
    logic bias_en;
    logic div_start;
    logic commit;
    logic copy_act;
  } lrn_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
  } lrn_sts_t;

  function automatic logic signed [9:0] squash_tab(input logic [4:0] k);
    logic signed [9:0] r;
    case (k)
      5'd0: r = 10'sd0;     5'd1: r = 10'sd63;   5'd2: r = 10'sd118;
      5'd3: r = 10'sd163;   5'd4: r = 10'sd195;  5'd5: r = 10'sd217;
      5'd6: r = 10'sd232;   5'd7: r = 10'sd241;  5'd8: r = 10'sd247;
      5'd9: r = 10'sd250;   5'd10: r = 10'sd253; 5'd11: r = 10'sd254;
      5'd12: r = 10'sd255;  5'd13: r = 10'sd255;
      default: r = 10'sd256;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] squash(input logic signed [15:0] m);
    logic [15:0] mag;
    logic [8:0] idx;
    logic [6:0] frac;
    logic signed [9:0] a, b;
    logic signed [17:0] p;
    logic signed [9:0] r;
    mag = m[15] ? 16'(-m) : m;
    idx = mag[15:7];
    frac = mag[6:0];
    if (idx >= 9'd16) begin
      r = 10'sd256;
    end else begin
      a = squash_tab(idx[4:0]);
      b = squash_tab(5'(idx[4:0] + 5'd1));
      p = 18'(b - a) * $signed({1'b0, frac}) + 18'sd64;
      r = a + 10'(p >>> 7);
    end
    return m[15] ? 16'(-r) : 16'(r);
  endfunction

endpackage

// ----- hdl/lrn_ctrl.sv -----
// Sequencer for the leaky recurrent network step core.
// Depends on lrn_pkg for command and status types.
module lrn_ctrl #(
  parameter int LAYERS = lrn_pkg::LAYERS_DEF,
  parameter int NW = lrn_pkg::NUM_ACTIONS_DEF + lrn_pkg::MEM_WORDS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_step_i,
  input  logic start_clr_i,
  input  lrn_pkg::lrn_sts_t sts_i,
  input  logic out_free_i,
  output lrn_pkg::lrn_cmd_t cmd_o,
  output logic busy_o,
  output logic done_o,
  output logic [$clog2(LAYERS)-1:0] layer_o,
  output logic [$clog2(NW)-1:0] neuron_o,
  output logic [$clog2(NW+2)-1:0] slot_o
);
  import lrn_pkg::*;

  localparam int LW = $clog2(LAYERS) > 0 ? $clog2(LAYERS) : 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_LDACT = 4'd1, S_RD = 4'd2, S_MAC = 4'd3,
                         S_BIAS = 4'd4, S_DIV = 4'd5, S_WAITD = 4'd6, S_COMMIT = 4'd7,
                         S_COPY = 4'd8, S_OUT = 4'd9, S_CLR = 4'd10, S_RD2 = 4'd11;

  logic [3:0] state_q, state_d;
  logic [$clog2(LAYERS)-1:0] l_q, l_d;
  logic [$clog2(NW)-1:0] n_q, n_d;
  logic [$clog2(NW+2)-1:0] w_q, w_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      l_q <= '0;
      n_q <= '0;
      w_q <= '0;
    end else begin
      state_q <= state_d;
      l_q <= l_d;
      n_q <= n_d;
      w_q <= w_d;
    end
  end

  always_comb begin
    state_d = state_q;
    l_d = l_q;
    n_d = n_q;
    w_d = w_q;
    cmd_o = '0;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_step_i) begin
          state_d = S_LDACT;
          l_d = '0;
          n_d = '0;
        end else if (start_clr_i) begin
          state_d = S_CLR;
          cmd_o.clr_start = 1'b1;
        end
      end
      S_CLR: if (sts_i.clr_done) state_d = S_IDLE;
      S_LDACT: begin
        cmd_o.ld_act = 1'b1;
        w_d = '0;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.acc_clr = 1'b1;
        w_d = w_q + 1'b1;
        state_d = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_en = 1'b1;
        w_d = w_q + 1'b1;
        if (32'(w_q) == NW + 1) state_d = S_BIAS;
      end
      S_BIAS: begin
        cmd_o.bias_en = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAITD;
      end
      S_WAITD: if (sts_i.div_done) state_d = S_COMMIT;
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        w_d = '0;
        if (32'(n_q) == NW - 1) begin
          n_d = '0;
          state_d = S_COPY;
        end else begin
          n_d = n_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_COPY: begin
        cmd_o.copy_act = 1'b1;
        if (32'(l_q) == LAYERS - 1) begin
          state_d = S_OUT;
        end else begin
          l_d = LW'(l_q + 1'b1);
          state_d = S_RD2;
        end
      end
      S_RD2: state_d = S_RD;
      S_OUT: if (out_free_i) begin
        done_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign layer_o = l_q;
  assign neuron_o = n_q;
  assign slot_o = w_q;

endmodule

// ----- hdl/lrn_div.sv -----
// Restoring divider for the leaky step: quotient of |d|*256 by 256+tau, rounded.
// Depends on nothing beyond plain logic; one quotient bit per cycle.
module lrn_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [24:0] num_i,
  input  logic [15:0] den_i,
  output logic done_o,
  output logic [24:0] quo_o
);
  logic [24:0] n_q, n_d;
  logic [16:0] r_q, r_d;
  logic [16:0] den_q;
  logic [4:0] cnt_q;
  logic run_q;
  logic [17:0] t;

  always_comb begin
    t = {r_q, n_q[24]};
    if (t >= {1'b0, den_q}) begin
      r_d = 17'(t - {1'b0, den_q});
      n_d = {n_q[23:0], 1'b1};
    end else begin
      r_d = t[16:0];
      n_d = {n_q[23:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd24) begin
          run_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      r_q <= '0;
      den_q <= {1'b0, den_i};
    end else if (run_q) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign quo_o = n_q;

endmodule

// ----- hdl/lrn_dp.sv -----
// Datapath: weight memory, history, activations, shared MAC and leaky update.
// Depends on lrn_pkg and lrn_div.
module lrn_dp #(
  parameter int LAYERS = lrn_pkg::LAYERS_DEF,
  parameter int NUM_ACTIONS = lrn_pkg::NUM_ACTIONS_DEF,
  parameter int NUM_STATES = lrn_pkg::NUM_STATES_DEF,
  parameter int MEM_WORDS = lrn_pkg::MEM_WORDS_DEF,
  parameter int NW = NUM_ACTIONS + MEM_WORDS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  lrn_pkg::lrn_cmd_t cmd_i,
  output lrn_pkg::lrn_sts_t sts_o,
  input  logic [$clog2(LAYERS)-1:0] layer_i,
  input  logic [$clog2(NW)-1:0] neuron_i,
  input  logic [$clog2(NW+2)-1:0] slot_i,
  input  logic wr_en_i,
  input  logic [1:0] wr_layer_i,
  input  logic [3:0] wr_neuron_i,
  input  logic [3:0] wr_slot_i,
  input  logic signed [15:0] wr_value_i,
  input  logic [3:0] state_bits_i,
  output logic [NUM_ACTIONS-1:0] action_o
);
  import lrn_pkg::*;

  localparam int NDATA = NW + 2;
  localparam int DEPTH = LAYERS * NW * NDATA;
  localparam int AW = $clog2(DEPTH);
  localparam int HDEPTH = LAYERS * NW;
  localparam int HW = $clog2(HDEPTH) > 0 ? $clog2(HDEPTH) : 1;
  localparam int WW = $clog2(NDATA);

  logic signed [15:0] wmem [DEPTH];
  logic signed [15:0] rd_q;
  logic signed [15:0] act_q [NW];
  logic signed [15:0] nxt_q [NW];
  logic signed [15:0] mem_q [MEM_WORDS];
  logic signed [15:0] hmem [HDEPTH];
  logic signed [15:0] hrd_q;
  logic [HDEPTH-1:0] hval_q;
  logic hval_rd_q;
  logic signed [15:0] hist;
  logic signed [47:0] acc_q;
  logic signed [15:0] tau_q;
  logic neg_q;
  logic clr_run_q;
  logic [WW-1:0] wprev_q;
  logic [HW-1:0] hidx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_ok;
  logic signed [24:0] rnd;
  logic signed [16:0] dd;
  logic [16:0] dmag;
  logic [15:0] den;
  logic [24:0] num;
  logic [24:0] quo;
  logic signed [17:0] newv;
  logic signed [15:0] sat_new;
  logic div_done;
  logic div_done_q;

  assign hidx = HW'(32'(layer_i) * NW + 32'(neuron_i));
  assign rd_addr = AW'((32'(layer_i) * NW + 32'(neuron_i)) * NDATA + 32'(slot_i));
  assign wr_addr = AW'((32'(wr_layer_i) * NW + 32'(wr_neuron_i)) * NDATA + 32'(wr_slot_i));
  assign wr_ok = wr_en_i && 32'(wr_layer_i) < LAYERS && 32'(wr_neuron_i) < NW
                 && 32'(wr_slot_i) < NDATA;

  always_ff @(posedge clk_i) begin
    if (wr_ok) wmem[wr_addr] <= wr_value_i;
    rd_q <= wmem[rd_addr];
    wprev_q <= slot_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.mac_en) begin
      if (32'(wprev_q) < NW) acc_q <= acc_q + 48'(rd_q * act_q[wprev_q[$clog2(NW)-1:0]]);
      else tau_q <= rd_q[15] ? 16'sd0 : rd_q;
    end else if (cmd_i.bias_en) begin
      acc_q <= acc_q + 48'($signed({rd_q, 8'd0}));
    end
  end

  always_comb begin
    logic signed [47:0] v;
    v = (acc_q + 48'sd128) >>> 8;
    if (v > 48'sd32767) rnd = 25'sd32767;
    else if (v < -48'sd32768) rnd = -25'sd32768;
    else rnd = 25'(v);
  end

  // History entries not written since the last clear read as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) hmem[hidx] <= sat_new;
    hrd_q <= hmem[hidx];
    hval_rd_q <= hval_q[hidx];
  end

  assign hist = hval_rd_q ? hrd_q : 16'sd0;

  assign dd = 17'(rnd) - 17'(hist);
  assign dmag = dd[16] ? 17'(-dd) : 17'(dd);
  assign den = 16'd256 + 16'(tau_q);
  assign num = {dmag, 8'd0} + 25'(den[15:1]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) neg_q <= dd[16];
  end

  lrn_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.div_start),
    .num_i(num), .den_i(den),
    .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i) div_done_q <= div_done;

  always_comb begin
    logic signed [17:0] q;
    q = quo[24:17] != 8'd0 ? 18'sd65535 : 18'($signed({1'b0, quo[16:0]}));
    newv = 18'(hist) + (neg_q ? -q : q);
    if (newv > 18'sd32767) sat_new = 16'sd32767;
    else if (newv < -18'sd32768) sat_new = -16'sd32768;
    else sat_new = 16'(newv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_run_q <= 1'b0;
      hval_q <= '0;
      for (int i = 0; i < MEM_WORDS; i++) mem_q[i] <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        hval_q <= '0;
        for (int i = 0; i < MEM_WORDS; i++) mem_q[i] <= '0;
      end else begin
        if (cmd_i.commit) hval_q[hidx] <= 1'b1;
        if (cmd_i.copy_act && 32'(layer_i) == LAYERS - 1) begin
          for (int i = 0; i < MEM_WORDS; i++) mem_q[i] <= nxt_q[NUM_ACTIONS+i];
        end
      end
      clr_run_q <= cmd_i.clr_start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) nxt_q[neuron_i] <= sat_new;
    if (cmd_i.ld_act) begin
      for (int i = 0; i < NW; i++) begin
        if (i < NUM_STATES) act_q[i] <= (i < 4 && state_bits_i[i % 4]) ? 16'sd256 : 16'sd0;
        else if (i - NUM_STATES < MEM_WORDS) act_q[i] <= squash(mem_q[i-NUM_STATES]);
        else act_q[i] <= '0;
      end
    end else if (cmd_i.copy_act) begin
      for (int i = 0; i < NW; i++) act_q[i] <= nxt_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_ACTIONS; i++) action_o[i] = !act_q[i][15] && act_q[i] != 16'sd0;
  end

  assign sts_o.clr_done = clr_run_q;
  assign sts_o.div_done = div_done_q;

endmodule

// ----- hdl/leaky_recurrent_net_step_core.sv -----
// Channel  Dir  Fields (tdata/tuser low bit up)
// s_axis   in   tuser: func[1:0]
//               tdata: layer[1:0] neuron[5:2] slot[9:6] weight_value[25:10]
//                      state_bits[29:26], padded to 32 bits
// m_axis   out  tdata: action_bits[3:0], padded to 8 bits
// A step holds the input until it ends: each neuron takes a read, a MAC pass over its
// weights and tau, a bias add, a serial divide and a commit, and each layer a copy.
// Reset is asynchronous and clears history and memory at once. A result still waiting
// holds the next step in its output state until taken.
module leaky_recurrent_net_step_core #(
  parameter int LAYERS = lrn_pkg::LAYERS_DEF,
  parameter int NUM_ACTIONS = lrn_pkg::NUM_ACTIONS_DEF,
  parameter int NUM_STATES = lrn_pkg::NUM_STATES_DEF,
  parameter int MEM_WORDS = lrn_pkg::MEM_WORDS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // layer, neuron, slot, weight_value, state_bits
  input  logic [1:0] s_axis_tuser,   // func
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata   // action_bits, zero padding
);
  import lrn_pkg::*;

  localparam int NW = NUM_ACTIONS + MEM_WORDS;

  lrn_cmd_t cmd;
  lrn_sts_t sts;
  logic busy, done, acc;
  logic [$clog2(LAYERS)-1:0] lay;
  logic [$clog2(NW)-1:0] neu;
  logic [$clog2(NW+2)-1:0] slt;
  logic [NUM_ACTIONS-1:0] act;
  logic [3:0] sbits_q;
  logic [3:0] out_q;
  logic ov_q;

  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) if (acc) sbits_q <= s_axis_tdata[29:26];

  lrn_ctrl #(.LAYERS(LAYERS), .NW(NW)) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .start_step_i(acc && s_axis_tuser == FUNC_STEP),
    .start_clr_i(acc && s_axis_tuser == FUNC_CLEAR),
    .sts_i(sts), .out_free_i(!ov_q || m_axis_tready),
    .cmd_o(cmd), .busy_o(busy), .done_o(done),
    .layer_o(lay), .neuron_o(neu), .slot_o(slt)
  );

  lrn_dp #(.LAYERS(LAYERS), .NUM_ACTIONS(NUM_ACTIONS), .NUM_STATES(NUM_STATES),
           .MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts),
    .layer_i(lay), .neuron_i(neu), .slot_i(slt),
    .wr_en_i(acc && s_axis_tuser == FUNC_WRITE),
    .wr_layer_i(s_axis_tdata[1:0]), .wr_neuron_i(s_axis_tdata[5:2]),
    .wr_slot_i(s_axis_tdata[9:6]), .wr_value_i(s_axis_tdata[25:10]),
    .state_bits_i(sbits_q), .action_o(act)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (done) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) if (done) out_q <= 4'(act);

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {4'd0, out_q};

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("ready while busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy) else $error("done outside a step");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

endmodule
